// ----- rtl/masked_palette_sprite_decoder_defines.svh -----
// Assertion macros for the masked palette sprite decoder.
// Expects clk and rst in the scope of the module that uses them.
`ifndef MASKED_PALETTE_SPRITE_DECODER_DEFINES_SVH
`define MASKED_PALETTE_SPRITE_DECODER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define MPSD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define MPSD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mpsd_pkg.sv -----
// Shared types and constants of the masked palette sprite decoder.
// No dependencies; imported by mpsd_ctrl, mpsd_dp and the top level.
`default_nettype none

package mpsd_pkg;

  localparam int unsigned PAL_ENTRIES_DEF = 256;
  localparam int unsigned CFG_DATA_W      = 16;

  // func codes of an input beat
  localparam logic [1:0] FUNC_PAL   = 2'd0;
  localparam logic [1:0] FUNC_DATA  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MASKED = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;
  localparam logic [1:0] CFG_PCOUNT = 2'd3;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [3:0] MASK_BITS    = 4'd8;

  typedef struct packed {
    logic mask_load;
    logic emit_color;
    logic emit_clear;
    logic group_end;
  } mpsd_cmd_t;

  typedef struct packed {
    logic skip;
    logic masked;
    logic expect_mask;
    logic fin;
    logic color_more;
    logic clear_now;
    logic slot_free;
  } mpsd_stat_t;

endpackage

`default_nettype wire

// ----- rtl/mpsd_ctrl.sv -----
// Controller of the sprite decoder: sequences decode, palette read and pixel emission.
// Depends on mpsd_pkg; drives mpsd_dp through mpsd_cmd_t and reads mpsd_stat_t.
`default_nettype none

module mpsd_ctrl
  import mpsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] func,
  output logic            in_ready,
  input  wire mpsd_stat_t stat,
  output mpsd_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_COLOR,
    S_ADV
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready && func == FUNC_DATA) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.skip) begin
          state_next = S_IDLE;
        end else if (!stat.masked || !stat.expect_mask) begin
          state_next = S_COLOR;
        end else begin
          cmd.mask_load = 1'b1;
          state_next    = stat.fin ? S_IDLE : S_ADV;
        end
      end
      S_COLOR: begin
        if (stat.slot_free) begin
          cmd.emit_color = 1'b1;
          state_next     = stat.color_more ? S_ADV : S_IDLE;
        end
      end
      S_ADV: begin
        // emit clear-bit pixels until a set bit waits or the group closes
        if (stat.clear_now) begin
          cmd.emit_clear = stat.slot_free;
        end else begin
          cmd.group_end = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mpsd_dp.sv -----
// Datapath of the sprite decoder: config registers, palette RAM, sprite state, output register.
// Depends on mpsd_pkg; commanded by mpsd_ctrl.
`default_nettype none

module mpsd_dp
  import mpsd_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_accept,
  input  wire logic [1:0]            func,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  final_byte,
  input  wire logic [7:0]            entry_index,
  input  wire logic [7:0]            entry_red,
  input  wire logic [7:0]            entry_green,
  input  wire logic [7:0]            entry_blue,
  input  wire mpsd_cmd_t             cmd,
  output mpsd_stat_t                 stat,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [7:0]                 pixel_blue,
  output logic [7:0]                 pixel_green,
  output logic [7:0]                 pixel_red,
  output logic [7:0]                 pixel_alpha,
  output logic                       bad_index,
  output logic                       run_end
);

  localparam int unsigned IDX_W   = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [8:0]  CNT_MAX = 9'(PALETTE_ENTRIES);

  // configuration
  logic        masked_mode;
  logic [15:0] line_width;
  logic [15:0] sprite_height;
  logic [8:0]  palette_count;
  logic [31:0] total_pixels;

  // sprite state
  logic [7:0]  current_mask;
  logic [3:0]  mask_bit_pos;
  logic        expect_mask;
  logic [15:0] column_pos;
  logic [31:0] pixels_emitted;
  logic        halted;

  logic [7:0]  byte_reg;
  logic        fin_reg;

  logic [23:0] pal_mem [PALETTE_ENTRIES];
  logic [23:0] rd_data;
  logic        pal_we;

  logic [8:0]  cnt_eff;
  logic        bad;
  logic [3:0]  pos_inc;
  logic [15:0] col_inc;
  logic [31:0] pe_inc;
  logic        clear_after;
  logic        emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      masked_mode   <= 1'b0;
      line_width    <= '0;
      sprite_height <= '0;
      palette_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MASKED: masked_mode   <= cfg_data[0];
        CFG_WIDTH:  line_width    <= cfg_data[15:0];
        CFG_HEIGHT: sprite_height <= cfg_data[15:0];
        CFG_PCOUNT: palette_count <= cfg_data[8:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    total_pixels <= 32'(line_width) * 32'(sprite_height);
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      byte_reg <= data_byte;
      fin_reg  <= final_byte;
    end
  end

  // palette RAM: one write port, one registered read port
  assign pal_we = in_accept && (func == FUNC_PAL) && ({1'b0, entry_index} < CNT_MAX);

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[entry_index[IDX_W-1:0]] <= {entry_red, entry_green, entry_blue};
    end
    rd_data <= pal_mem[byte_reg[IDX_W-1:0]];
  end

  assign cnt_eff = (palette_count > CNT_MAX) ? CNT_MAX : palette_count;
  assign bad     = ({1'b0, byte_reg} >= cnt_eff);
  assign pos_inc = mask_bit_pos + 4'd1;
  assign col_inc = column_pos + 16'd1;
  assign pe_inc  = pixels_emitted + 32'd1;

  // would another clear-bit pixel follow once the current pixel is out
  assign clear_after = (pos_inc < MASK_BITS) && (col_inc < line_width) &&
                       (pe_inc < total_pixels) && !current_mask[~pos_inc[2:0]];

  assign stat.skip        = halted || (pixels_emitted >= total_pixels);
  assign stat.masked      = masked_mode;
  assign stat.expect_mask = expect_mask;
  assign stat.fin         = fin_reg;
  assign stat.color_more  = masked_mode && !bad && !fin_reg;
  assign stat.clear_now   = (mask_bit_pos < MASK_BITS) && (column_pos < line_width) &&
                            (pixels_emitted < total_pixels) &&
                            !current_mask[~mask_bit_pos[2:0]];
  assign stat.slot_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst || (in_accept && func == FUNC_START)) begin
      current_mask   <= '0;
      mask_bit_pos   <= '0;
      expect_mask    <= 1'b1;
      column_pos     <= '0;
      pixels_emitted <= '0;
      halted         <= 1'b0;
    end else begin
      if (cmd.mask_load) begin
        current_mask <= byte_reg;
        mask_bit_pos <= '0;
        expect_mask  <= 1'b0;
        if (fin_reg) begin
          halted <= 1'b1;
        end
      end
      if (cmd.emit_color) begin
        if (bad) begin
          halted <= 1'b1;
        end else begin
          pixels_emitted <= pe_inc;
          if (fin_reg) begin
            halted <= 1'b1;
          end
          if (masked_mode) begin
            mask_bit_pos <= pos_inc;
            column_pos   <= col_inc;
          end
        end
      end
      if (cmd.emit_clear) begin
        pixels_emitted <= pe_inc;
        mask_bit_pos   <= pos_inc;
        column_pos     <= col_inc;
      end
      if (cmd.group_end) begin
        if (mask_bit_pos >= MASK_BITS || column_pos >= line_width) begin
          expect_mask <= 1'b1;
          if (column_pos == line_width) begin
            column_pos <= '0;
          end
        end
      end
    end
  end

  // output register: load on emit, drop once the beat is taken
  assign emit = cmd.emit_color || cmd.emit_clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_color) begin
      if (bad) begin
        pixel_blue  <= '0;
        pixel_green <= '0;
        pixel_red   <= '0;
        pixel_alpha <= '0;
        bad_index   <= 1'b1;
        run_end     <= 1'b1;
      end else begin
        pixel_blue  <= rd_data[7:0];
        pixel_green <= rd_data[15:8];
        pixel_red   <= rd_data[23:16];
        pixel_alpha <= ALPHA_OPAQUE;
        bad_index   <= 1'b0;
        run_end     <= !masked_mode || fin_reg || !clear_after;
      end
    end else if (cmd.emit_clear) begin
      pixel_blue  <= '0;
      pixel_green <= '0;
      pixel_red   <= '0;
      pixel_alpha <= '0;
      bad_index   <= 1'b0;
      run_end     <= !clear_after;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/masked_palette_sprite_decoder.sv -----
// Masked palette sprite decoder, top level: ties controller and datapath together.
// Depends on mpsd_pkg, mpsd_ctrl, mpsd_dp and masked_palette_sprite_decoder_defines.svh.
`default_nettype none
`include "masked_palette_sprite_decoder_defines.svh"

// Turns a sprite byte stream into BGRA pixels through an on-chip palette RAM.
// Palette writes and start beats are taken in S_IDLE and yield no output. A data
// byte is accepted in S_IDLE and decoded in S_EVAL while the palette RAM is read;
// its pixels leave through S_COLOR and S_ADV (one pixel per cycle while out_ready
// is high), and S_ADV closes a mask scan when clear bits are scanned after it. A
// plain-mode byte thus passes S_IDLE, S_EVAL and S_COLOR. The palette RAM read is
// registered, a single pixel emitter drives the output, and a stall pauses emission.
// A new beat is taken while the last pixel of the previous byte still waits in
// the output register. A bad palette index yields one result with bad_index set
// and halts decoding until a start beat. The palette RAM holds no reset value:
// program every entry below palette_count before decoding.
module masked_palette_sprite_decoder
  import mpsd_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            func,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  final_byte,
  input  wire logic [7:0]            entry_index,
  input  wire logic [7:0]            entry_red,
  input  wire logic [7:0]            entry_green,
  input  wire logic [7:0]            entry_blue,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 pixel_blue,
  output logic [7:0]                 pixel_green,
  output logic [7:0]                 pixel_red,
  output logic [7:0]                 pixel_alpha,
  output logic                       bad_index,
  output logic                       run_end
);

  mpsd_cmd_t  cmd;
  mpsd_stat_t stat;
  logic       in_accept;

  assign in_accept = in_valid && in_ready;

  mpsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mpsd_dp #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_accept   (in_accept),
    .func        (func),
    .data_byte   (data_byte),
    .final_byte  (final_byte),
    .entry_index (entry_index),
    .entry_red   (entry_red),
    .entry_green (entry_green),
    .entry_blue  (entry_blue),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .pixel_blue  (pixel_blue),
    .pixel_green (pixel_green),
    .pixel_red   (pixel_red),
    .pixel_alpha (pixel_alpha),
    .bad_index   (bad_index),
    .run_end     (run_end)
  );

  // a byte whose run is not finished keeps the input closed
  `MPSD_ASSERT_IMP(a_run_blocks_input, out_valid && !run_end, !in_ready, "input open mid-run")
  // an error beat carries no pixel and ends its run
  `MPSD_ASSERT_IMP(a_bad_is_last, out_valid && bad_index, pixel_alpha == 8'd0 && run_end,
                   "bad index beat malformed")
  // only one pixel source drives the output register
  `MPSD_ASSERT_IMP(a_one_source, 1'b1, !(cmd.emit_color && cmd.emit_clear),
                   "two pixel sources at once")
  // an emitted pixel shows up as an output beat
  `MPSD_ASSERT_NXT(a_emit_shows, cmd.emit_color || cmd.emit_clear, out_valid,
                   "emitted pixel lost")

endmodule

`default_nettype wire
